// ===== rtl/apq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the array priority queue.
// No dependencies; every other file except apq_ram refers to this package by scoped names.
package apq_pkg;

    typedef logic signed [31:0] value_t;
    typedef logic signed [15:0] prio_t;
    typedef logic        [1:0]  status_t;
    typedef logic        [4:0]  cap_t;
    typedef logic        [4:0]  occ_t;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam status_t ST_DONE  = 2'd0;
    localparam status_t ST_FULL  = 2'd1;
    localparam status_t ST_EMPTY = 2'd2;

    localparam cap_t CAP_RESET = 5'd16;

    typedef struct packed {
        value_t value;
        prio_t  prio;
    } entry_t;

    typedef struct packed {
        logic first;
        logic sample;
    } best_ctl_t;

endpackage

// ===== rtl/apq_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and result items.
// Depends on apq_pkg for the payload types.
interface apq_in_if;
    logic            valid;
    logic            ready;
    logic            opcode;
    apq_pkg::value_t item_value;
    apq_pkg::prio_t  item_priority;

    modport source (output valid, output opcode, output item_value, output item_priority,
                    input ready);
    modport sink   (input valid, input opcode, input item_value, input item_priority,
                    output ready);
endinterface

interface apq_out_if;
    logic             valid;
    logic             ready;
    apq_pkg::status_t status;
    apq_pkg::value_t  removed_value;
    apq_pkg::prio_t   removed_priority;
    apq_pkg::occ_t    occupancy;

    modport source (output valid, output status, output removed_value,
                    output removed_priority, output occupancy, input ready);
    modport sink   (input valid, input status, input removed_value,
                    input removed_priority, input occupancy, output ready);
endinterface

// ===== rtl/apq_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module apq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/apq_best_unit.sv =====
`timescale 1ns / 1ps
// Shared compare unit: tracks the highest priority entry seen during a scan.
// Depends on apq_pkg for entry and control types.
module apq_best_unit #(
    parameter int IW = 4
) (
    input  logic              clk,
    input  apq_pkg::best_ctl_t ctl,
    input  logic [IW-1:0]     idx,
    input  apq_pkg::entry_t   entry,
    output logic [IW-1:0]     best_idx,
    output apq_pkg::entry_t   best_entry
);

    logic            take;
    logic [IW-1:0]   best_idx_reg;
    apq_pkg::entry_t best_entry_reg;

    // strictly greater keeps the oldest entry on ties
    assign take = ctl.sample &&
                  (ctl.first || ($signed(entry.prio) > $signed(best_entry_reg.prio)));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg   <= idx;
            best_entry_reg <= entry;
        end
    end

    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;

endmodule

// ===== rtl/array_priority_queue.sv =====
`timescale 1ns / 1ps
// Priority queue in an unsorted RAM array with one shared priority comparator.
// Sequence: an enqueue or an empty dequeue goes from S_DECIDE to S_POST; a dequeue
// of held entries scans them all, picks the best index b, then shifts the entries above
// b down one place, paced by the single RAM read port feeding the comparator and the shift.
// Flow: ready only while idle, so a new item is taken only after the last result is registered.
// Reset: queue empty, capacity limit 16, RAM contents left undefined.
module array_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  apq_pkg::cap_t     cfg_wr_data,
    apq_in_if.sink            in_ch,
    apq_out_if.source         out_ch
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int NW = CW + 1;
    localparam int LW = (CW > 5) ? CW : 5;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_POST   = 3'd5;

    logic [2:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    apq_pkg::cap_t    cap_reg;
    logic             op_reg;
    apq_pkg::entry_t  item_reg;
    apq_pkg::status_t res_status_reg, res_status_next;

    logic             out_valid_reg, out_valid_next;
    apq_pkg::status_t out_status_reg;
    apq_pkg::value_t  out_value_reg;
    apq_pkg::prio_t   out_prio_reg;
    apq_pkg::occ_t    out_occ_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    apq_pkg::entry_t  ram_wdata;
    logic [AW-1:0]    ram_raddr;
    apq_pkg::entry_t  ram_rdata;

    apq_pkg::best_ctl_t best_ctl;
    logic [AW-1:0]      best_idx;
    apq_pkg::entry_t    best_entry;

    logic             full;
    logic             out_free;
    logic             in_fire;
    logic [NW-1:0]    cnt_n;
    logic [NW-1:0]    idx_inc;
    logic [NW-1:0]    idx_inc2;
    logic [NW-1:0]    best_inc;
    logic [LW-1:0]    occ_wide;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign out_free = !out_valid_reg || out_ch.ready;
    assign cnt_n    = NW'(count_reg);
    assign idx_inc  = NW'(idx_reg) + NW'(1);
    assign idx_inc2 = NW'(idx_reg) + NW'(2);
    assign best_inc = NW'(best_idx) + NW'(1);
    assign full     = (LW'(count_reg) >= LW'(cap_reg)) || (cnt_n == NW'(DEPTH));
    assign occ_wide = LW'(count_reg);

    apq_ram #(
        .WIDTH ($bits(apq_pkg::entry_t)),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    apq_best_unit #(
        .IW (AW)
    ) u_best (
        .clk        (clk),
        .ctl        (best_ctl),
        .idx        (idx_reg),
        .entry      (ram_rdata),
        .best_idx   (best_idx),
        .best_entry (best_entry)
    );

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        res_status_next = res_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = ram_rdata;
        ram_raddr       = '0;
        best_ctl.first  = 1'b0;
        best_ctl.sample = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                if (op_reg == apq_pkg::OP_ENQ)
                begin
                    state_next = S_POST;
                    if (full)
                    begin
                        res_status_next = apq_pkg::ST_FULL;
                    end
                    else
                    begin
                        res_status_next = apq_pkg::ST_DONE;
                        ram_we          = 1'b1;
                        ram_waddr       = count_reg[AW-1:0];
                        ram_wdata       = item_reg;
                        count_next      = count_reg + CW'(1);
                    end
                end
                else if (count_reg == '0)
                begin
                    res_status_next = apq_pkg::ST_EMPTY;
                    state_next      = S_POST;
                end
                else
                begin
                    res_status_next = apq_pkg::ST_DONE;
                    ram_raddr       = '0;
                    idx_next        = '0;
                    state_next      = S_SCAN;
                end
            end
            S_SCAN:
            begin
                // data for idx_reg arrives; prefetch the next entry
                best_ctl.sample = 1'b1;
                best_ctl.first  = (idx_reg == '0);
                ram_raddr       = idx_inc[AW-1:0];
                if (idx_inc == cnt_n)
                begin
                    state_next = S_PICK;
                end
                else
                begin
                    idx_next = idx_inc[AW-1:0];
                end
            end
            S_PICK:
            begin
                if (best_inc == cnt_n)
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_POST;
                end
                else
                begin
                    ram_raddr  = best_inc[AW-1:0];
                    idx_next   = best_idx;
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                // move entry idx+1 down to idx
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                ram_wdata = ram_rdata;
                if (idx_inc2 < cnt_n)
                begin
                    ram_raddr = idx_inc2[AW-1:0];
                    idx_next  = idx_inc[AW-1:0];
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == S_POST && out_free)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            cap_reg        <= apq_pkg::CAP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        res_status_reg <= res_status_next;
        if (in_fire)
        begin
            op_reg        <= in_ch.opcode;
            item_reg.value <= in_ch.item_value;
            item_reg.prio  <= in_ch.item_priority;
        end
        if (state_reg == S_POST && out_free)
        begin
            out_status_reg <= res_status_reg;
            out_occ_reg    <= occ_wide[4:0];
            if (op_reg == apq_pkg::OP_DEQ && res_status_reg == apq_pkg::ST_DONE)
            begin
                out_value_reg <= best_entry.value;
                out_prio_reg  <= best_entry.prio;
            end
            else
            begin
                out_value_reg <= '0;
                out_prio_reg  <= '0;
            end
        end
    end

    assign in_ch.ready             = (state_reg == S_IDLE);
    assign out_ch.valid            = out_valid_reg;
    assign out_ch.status           = out_status_reg;
    assign out_ch.removed_value    = out_value_reg;
    assign out_ch.removed_priority = out_prio_reg;
    assign out_ch.occupancy        = out_occ_reg;

    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        NW'(count_reg) <= NW'(DEPTH))
        else $error("entry count exceeds depth");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> state_reg == S_DECIDE)
        else $error("accepted item did not start decode");

    a_enq_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE && op_reg == apq_pkg::OP_ENQ && !full)
        |=> count_reg == $past(count_reg) + CW'(1))
        else $error("enqueue did not grow the count");

    a_shift_needs_entries: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT |-> NW'(count_reg) >= NW'(2))
        else $error("shift with fewer than two entries");

    a_post_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POST && !out_free) |=> state_reg == S_POST)
        else $error("result dropped while output busy");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for array_priority_queue: directed and random enqueue/dequeue
// traffic, checked item by item against a behavioural queue model held in the bench.
// Depends on apq_pkg, apq_in_if, apq_out_if and the array_priority_queue RTL.
module tb_top;

    localparam int QDEPTH      = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 50;

    typedef struct packed {
        apq_pkg::status_t status;
        apq_pkg::value_t  rem_value;
        apq_pkg::prio_t   rem_prio;
        apq_pkg::occ_t    occ;
    } result_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    apq_pkg::cap_t cfg_wr_data;

    apq_in_if  in_if ();
    apq_out_if out_if ();

    array_priority_queue #(
        .DEPTH (QDEPTH)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_ch       (in_if),
        .out_ch      (out_if)
    );

    apq_pkg::value_t held_val [QDEPTH];
    apq_pkg::prio_t  held_pri [QDEPTH];
    int              held_cnt;
    apq_pkg::cap_t   cap_reg;
    result_t         due_results [$];

    int       errors;
    int       cycles;
    int       burst_left;
    bit       sender_steady;
    int       hold_cycles;
    int       pat_count;
    logic [7:0] stall_mask;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("MISMATCH %s: got %h expected %h (cycle %0d)", what, got, want, cycles);
    endtask

    function automatic void apply_queue_op(input logic op, input apq_pkg::value_t v,
                                           input apq_pkg::prio_t p);
        result_t r;
        int      lim;
        int      best;
        int      i;
        r        = '0;
        r.status = apq_pkg::ST_DONE;
        lim      = (cap_reg > QDEPTH) ? QDEPTH : int'(cap_reg);
        if (op == apq_pkg::OP_ENQ)
        begin
            if (held_cnt >= lim)
                r.status = apq_pkg::ST_FULL;
            else
            begin
                held_val[held_cnt] = v;
                held_pri[held_cnt] = p;
                held_cnt++;
            end
        end
        else if (held_cnt == 0)
            r.status = apq_pkg::ST_EMPTY;
        else
        begin
            best = 0;
            for (i = 1; i < held_cnt; i++)
                if (held_pri[i] > held_pri[best])
                    best = i;
            r.rem_value = held_val[best];
            r.rem_prio  = held_pri[best];
            for (i = best; i + 1 < held_cnt; i++)
            begin
                held_val[i] = held_val[i + 1];
                held_pri[i] = held_pri[i + 1];
            end
            held_cnt--;
        end
        r.occ = apq_pkg::occ_t'(held_cnt);
        due_results.push_back(r);
    endfunction

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (due_results.size() == 0)
                report_mismatch("unexpected result", out_if.status, '0);
            else
            begin
                want = due_results.pop_front();
                if (out_if.status !== want.status)
                    report_mismatch("status", out_if.status, want.status);
                if (out_if.removed_value !== want.rem_value)
                    report_mismatch("removed_value", out_if.removed_value, want.rem_value);
                if (out_if.removed_priority !== want.rem_prio)
                    report_mismatch("removed_priority", out_if.removed_priority,
                                    want.rem_prio);
                if (out_if.occupancy !== want.occ)
                    report_mismatch("occupancy", out_if.occupancy, want.occ);
            end
        end
    end

    // receiver: long hold when asked, else a randomly drawn eight-bit stall pattern
    always @(negedge clk)
    begin
        if (!rst_n)
            out_if.ready = 1'b0;
        else if (hold_cycles > 0)
        begin
            out_if.ready = 1'b0;
            hold_cycles--;
        end
        else
        begin
            if (pat_count % 40 == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1: stall_mask = 8'hFF;
                    2:    stall_mask = 8'($urandom) | 8'h01;
                    default: stall_mask = 8'h11;
                endcase
            end
            out_if.ready = stall_mask[pat_count % 8];
            pat_count++;
        end
    end

    task automatic send_item(input logic op, input apq_pkg::value_t v,
                             input apq_pkg::prio_t p);
        int gap;
        @(negedge clk);
        in_if.valid         = 1'b1;
        in_if.opcode        = op;
        in_if.item_value    = v;
        in_if.item_priority = p;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        apply_queue_op(op, v, p);
        burst_left--;
        if (!sender_steady && burst_left <= 0)
        begin
            gap        = $urandom_range(1, 7);
            burst_left = $urandom_range(1, 12);
            @(negedge clk);
            in_if.valid = 1'b0;
            repeat (gap - 1)
                @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_if.valid = 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input apq_pkg::cap_t c);
        wait_drained();
        repeat (4)
            @(posedge clk);
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = c;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        cap_reg     = c;
    endtask

    function automatic apq_pkg::prio_t rand_prio();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return apq_pkg::prio_t'($urandom_range(0, 6) - 3);
        else if (pick < 6)
        begin
            case ($urandom_range(0, 3))
                0: return 16'sh7FFF;
                1: return 16'sh8000;
                2: return 16'sh0000;
                default: return 16'shFFFF;
            endcase
        end
        return apq_pkg::prio_t'($urandom);
    endfunction

    task automatic test_empty_dequeue();
        send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom), apq_pkg::prio_t'($urandom));
    endtask

    task automatic test_field_extremes();
        send_item(apq_pkg::OP_ENQ, 32'sh7FFFFFFF, 16'sh7FFF);
        send_item(apq_pkg::OP_ENQ, 32'sh80000000, 16'sh8000);
        send_item(apq_pkg::OP_ENQ, 32'sh00000000, 16'sh0000);
        send_item(apq_pkg::OP_ENQ, 32'shFFFFFFFF, 16'shFFFF);
        repeat (4)
            send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom),
                      apq_pkg::prio_t'($urandom));
    endtask

    task automatic test_equal_priority_order();
        send_item(apq_pkg::OP_ENQ, 32'sh0000_0A01, 16'sd7);
        send_item(apq_pkg::OP_ENQ, 32'sh0000_0A02, 16'sd7);
        send_item(apq_pkg::OP_ENQ, 32'sh0000_0A03, 16'sd9);
        repeat (3)
            send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom),
                      apq_pkg::prio_t'($urandom));
    endtask

    task automatic test_capacity_edges();
        write_capacity(5'd1);
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom), apq_pkg::prio_t'($urandom));
        write_capacity(5'd0);
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        write_capacity(apq_pkg::CAP_RESET);
    endtask

    task automatic test_capacity_below_held();
        repeat (3)
            send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        write_capacity(5'd2);
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom), apq_pkg::prio_t'($urandom));
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        send_item(apq_pkg::OP_DEQ, apq_pkg::value_t'($urandom), apq_pkg::prio_t'($urandom));
        send_item(apq_pkg::OP_ENQ, apq_pkg::value_t'($urandom), rand_prio());
        write_capacity(apq_pkg::CAP_RESET);
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        @(posedge clk);
        hold_cycles   = 200;
        sender_steady = 1'b1;
        repeat (10)
            send_item($urandom_range(0, 2) == 0 ? apq_pkg::OP_DEQ : apq_pkg::OP_ENQ,
                      apq_pkg::value_t'($urandom), rand_prio());
        wait_drained();
        sender_steady = 1'b0;
    endtask

    task automatic test_random_traffic(input int n_items);
        int   sent;
        int   phase;
        int   len;
        int   enq_pct;
        logic op;
        sent  = 0;
        phase = 0;
        while (sent < n_items)
        begin
            case (phase % 8)
                0: write_capacity(5'd16);
                1: write_capacity(5'd31);
                2: write_capacity(5'd1);
                3: write_capacity(5'd0);
                4: write_capacity(5'd17);
                5: write_capacity(5'd5);
                default: write_capacity(apq_pkg::cap_t'($urandom_range(0, 31)));
            endcase
            sender_steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: enq_pct = 80;
                1: enq_pct = 25;
                default: enq_pct = 50;
            endcase
            len = $urandom_range(20, 60);
            repeat (len)
            begin
                op = ($urandom_range(0, 99) < enq_pct) ? apq_pkg::OP_ENQ : apq_pkg::OP_DEQ;
                send_item(op, apq_pkg::value_t'($urandom), rand_prio());
                sent++;
            end
            phase++;
        end
        sender_steady = 1'b0;
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        in_if.valid         = 1'b0;
        in_if.opcode        = apq_pkg::OP_ENQ;
        in_if.item_value    = '0;
        in_if.item_priority = '0;
        out_if.ready        = 1'b0;
        errors              = 0;
        cycles              = 0;
        burst_left          = 4;
        sender_steady       = 1'b0;
        hold_cycles         = 0;
        pat_count           = 0;
        stall_mask          = 8'hFF;
        held_cnt            = 0;
        cap_reg             = apq_pkg::CAP_RESET;

        repeat (4)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_dequeue();
        test_field_extremes();
        test_equal_priority_order();
        test_capacity_edges();
        test_capacity_below_held();
        test_output_backpressure();
        test_random_traffic(600);

        wait_drained();
        repeat (40)
            @(posedge clk);
        if (due_results.size() != 0)
            report_mismatch("results still due", '0, due_results.size());
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
